@@ src/ags_pkg.sv @@
// Shared types, codes and defaults for the access gate sequencer.
package ags_pkg;

  localparam int AGS_TIMER_BITS    = 16;
  localparam int AGS_DISTANCE_BITS = 16;
  localparam int AGS_CFG_BITS      = 16;
  localparam int AGS_DIST_W        = 16;
  localparam int AGS_IDX_BITS      = 3;

  typedef logic [AGS_IDX_BITS-1:0] ags_idx_t;

  localparam ags_idx_t CFG_CAL_DIST     = 3'd0;
  localparam ags_idx_t CFG_PASS_TIMEOUT = 3'd1;
  localparam ags_idx_t CFG_HOLD_TIME    = 3'd2;
  localparam ags_idx_t CFG_CLOSE_TIME   = 3'd3;
  localparam ags_idx_t CFG_MSG_TIME     = 3'd4;
  localparam ags_idx_t CFG_MEAS_IVAL    = 3'd5;

  localparam logic [AGS_CFG_BITS-1:0] RST_CAL_DIST     = 16'd1000;
  localparam logic [AGS_CFG_BITS-1:0] RST_PASS_TIMEOUT = 16'd5000;
  localparam logic [AGS_CFG_BITS-1:0] RST_HOLD_TIME    = 16'd1000;
  localparam logic [AGS_CFG_BITS-1:0] RST_CLOSE_TIME   = 16'd1000;
  localparam logic [AGS_CFG_BITS-1:0] RST_MSG_TIME     = 16'd2000;
  localparam logic [AGS_CFG_BITS-1:0] RST_MEAS_IVAL    = 16'd10;

  typedef enum logic [2:0] {
    PH_WAIT      = 3'd0,
    PH_PASS_WAIT = 3'd1,
    PH_DETECTED  = 3'd2,
    PH_CLOSING   = 3'd3,
    PH_MESSAGE   = 3'd4
  } ags_phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2
  } ags_dir_t;

  localparam logic [1:0] DOOR_NONE  = 2'd0;
  localparam logic [1:0] DOOR_ENTRY = 2'd1;
  localparam logic [1:0] DOOR_EXIT  = 2'd2;
  localparam logic [1:0] DOOR_CLOSE = 2'd3;

  localparam logic [2:0] DISP_NONE    = 3'd0;
  localparam logic [2:0] DISP_WELCOME = 3'd1;
  localparam logic [2:0] DISP_GOODBYE = 3'd2;
  localparam logic [2:0] DISP_DENIED  = 3'd3;
  localparam logic [2:0] DISP_NO_PASS = 3'd4;
  localparam logic [2:0] DISP_WAITING = 3'd5;

  localparam logic [1:0] LOG_NONE     = 2'd0;
  localparam logic [1:0] LOG_DENIED   = 2'd1;
  localparam logic [1:0] LOG_NO_PASS  = 2'd2;
  localparam logic [1:0] LOG_COMPLETE = 2'd3;

  typedef struct packed {
    logic                  entry_card_seen;
    logic                  exit_card_seen;
    logic                  card_allowed;
    logic [AGS_DIST_W-1:0] distance;
  } ags_in_t;

  typedef struct packed {
    logic [1:0] door_command;
    logic [2:0] display_code;
    logic [1:0] log_event;
    logic       log_is_entry;
    logic [2:0] phase;
  } ags_out_t;

  typedef struct packed {
    logic [AGS_CFG_BITS-1:0] calibrated_distance;
    logic [AGS_CFG_BITS-1:0] passage_timeout;
    logic [AGS_CFG_BITS-1:0] detect_hold_time;
    logic [AGS_CFG_BITS-1:0] closing_time;
    logic [AGS_CFG_BITS-1:0] message_time;
    logic [AGS_CFG_BITS-1:0] measure_interval;
  } ags_cfg_t;

endpackage

@@ src/ags_cfg_regs.sv @@
// Configuration register file for the access gate sequencer.
module ags_cfg_regs
  import ags_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  ags_idx_t                wr_index,
  input  logic [AGS_CFG_BITS-1:0] wr_data,
  output ags_cfg_t                cfg
);

  ags_cfg_t cfg_r;
  ags_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_CAL_DIST:     cfg_nxt.calibrated_distance = wr_data;
        CFG_PASS_TIMEOUT: cfg_nxt.passage_timeout     = wr_data;
        CFG_HOLD_TIME:    cfg_nxt.detect_hold_time    = wr_data;
        CFG_CLOSE_TIME:   cfg_nxt.closing_time        = wr_data;
        CFG_MSG_TIME:     cfg_nxt.message_time        = wr_data;
        CFG_MEAS_IVAL:    cfg_nxt.measure_interval    = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calibrated_distance <= RST_CAL_DIST;
      cfg_r.passage_timeout     <= RST_PASS_TIMEOUT;
      cfg_r.detect_hold_time    <= RST_HOLD_TIME;
      cfg_r.closing_time        <= RST_CLOSE_TIME;
      cfg_r.message_time        <= RST_MSG_TIME;
      cfg_r.measure_interval    <= RST_MEAS_IVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/ags_step.sv @@
// Phase state machine and timers; computes one result per accepted request.
module ags_step
  import ags_pkg::*;
#(
  parameter int TIMER_BITS    = AGS_TIMER_BITS,
  parameter int DISTANCE_BITS = AGS_DISTANCE_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  ags_in_t  req,
  input  ags_cfg_t cfg,
  output ags_out_t result
);

  localparam int CMP_W = (TIMER_BITS > AGS_CFG_BITS) ? TIMER_BITS : AGS_CFG_BITS;
  localparam int THR_W = AGS_DIST_W + 5;
  localparam logic [AGS_DIST_W-1:0] DIST_MASK = (DISTANCE_BITS >= AGS_DIST_W) ?
      {AGS_DIST_W{1'b1}} : AGS_DIST_W'((64'd1 << DISTANCE_BITS) - 64'd1);

  typedef logic [TIMER_BITS-1:0] tmr_t;

  ags_phase_t phase_r, phase_nxt;
  ags_dir_t   dir_r, dir_nxt;
  tmr_t       elapsed_r, elapsed_nxt;
  tmr_t       since_r, since_nxt;

  tmr_t             elapsed_inc;
  tmr_t             since_inc;
  tmr_t             elapsed_det;
  logic             sample_due;
  logic             presence;
  logic             detect;
  logic             pass_exp;
  logic             hold_exp;
  logic             close_exp;
  logic             msg_exp;
  logic             card;
  logic [THR_W-1:0] dist_x10;
  logic [THR_W-1:0] cal_x9;
  logic [AGS_DIST_W-1:0] dist_m;
  logic [AGS_DIST_W-1:0] cal_m;

  // shared conditions
  always_comb begin
    elapsed_inc = (elapsed_r == {TIMER_BITS{1'b1}}) ? elapsed_r : elapsed_r + tmr_t'(1);
    since_inc   = (since_r == {TIMER_BITS{1'b1}}) ? since_r : since_r + tmr_t'(1);
    dist_m      = req.distance & DIST_MASK;
    cal_m       = cfg.calibrated_distance & DIST_MASK;
    // d < floor(9c/10)  <=>  10d + 10 <= 9c
    dist_x10    = (THR_W'(dist_m) << 3) + (THR_W'(dist_m) << 1) + THR_W'(10);
    cal_x9      = (THR_W'(cal_m) << 3) + THR_W'(cal_m);
    sample_due  = CMP_W'(since_inc) >= CMP_W'(cfg.measure_interval);
    presence    = (dist_m != '0) && (dist_x10 <= cal_x9);
    detect      = sample_due && presence;
    elapsed_det = detect ? '0 : elapsed_inc;
    pass_exp    = CMP_W'(elapsed_inc) >= CMP_W'(cfg.passage_timeout);
    hold_exp    = CMP_W'(elapsed_det) >= CMP_W'(cfg.detect_hold_time);
    close_exp   = CMP_W'(elapsed_inc) >= CMP_W'(cfg.closing_time);
    msg_exp     = CMP_W'(elapsed_inc) >= CMP_W'(cfg.message_time);
    card        = req.entry_card_seen || req.exit_card_seen;
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    dir_nxt     = dir_r;
    elapsed_nxt = elapsed_inc;
    since_nxt   = since_inc;
    case (phase_r)
      PH_PASS_WAIT: begin
        if (pass_exp) begin
          phase_nxt   = PH_MESSAGE;
          elapsed_nxt = '0;
        end else if (sample_due) begin
          since_nxt = '0;
          if (presence) begin
            phase_nxt   = PH_DETECTED;
            elapsed_nxt = '0;
          end
        end
      end
      PH_DETECTED: begin
        if (sample_due) begin
          since_nxt = '0;
        end
        elapsed_nxt = elapsed_det;
        if (hold_exp) begin
          phase_nxt   = PH_CLOSING;
          elapsed_nxt = '0;
        end
      end
      PH_CLOSING: begin
        if (close_exp) begin
          phase_nxt   = PH_WAIT;
          dir_nxt     = DIR_NONE;
          elapsed_nxt = '0;
        end
      end
      PH_MESSAGE: begin
        if (msg_exp) begin
          phase_nxt   = PH_WAIT;
          dir_nxt     = DIR_NONE;
          elapsed_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
        if (phase_r != PH_WAIT) begin
          dir_nxt = DIR_NONE;
        end
        if (card) begin
          dir_nxt     = req.entry_card_seen ? DIR_IN : DIR_OUT;
          phase_nxt   = req.card_allowed ? PH_PASS_WAIT : PH_MESSAGE;
          elapsed_nxt = '0;
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    result.door_command = DOOR_NONE;
    result.display_code = DISP_NONE;
    result.log_event    = LOG_NONE;
    result.log_is_entry = 1'b0;
    result.phase        = phase_nxt;
    case (phase_r)
      PH_PASS_WAIT: begin
        if (pass_exp) begin
          result.door_command = DOOR_CLOSE;
          result.display_code = DISP_NO_PASS;
          result.log_event    = LOG_NO_PASS;
          result.log_is_entry = (dir_r == DIR_IN);
        end
      end
      PH_DETECTED: begin
        if (hold_exp) begin
          result.log_event    = LOG_COMPLETE;
          result.log_is_entry = (dir_r == DIR_IN);
        end
      end
      PH_CLOSING: begin
        if (close_exp) begin
          result.door_command = DOOR_CLOSE;
          result.display_code = DISP_WAITING;
        end
      end
      PH_MESSAGE: begin
        if (msg_exp) begin
          result.display_code = DISP_WAITING;
        end
      end
      default: begin
        if (card && req.card_allowed) begin
          result.door_command = req.entry_card_seen ? DOOR_ENTRY : DOOR_EXIT;
          result.display_code = req.entry_card_seen ? DISP_WELCOME : DISP_GOODBYE;
        end else if (card) begin
          result.display_code = DISP_DENIED;
          result.log_event    = LOG_DENIED;
          result.log_is_entry = req.entry_card_seen;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      dir_r     <= DIR_NONE;
      elapsed_r <= '0;
      since_r   <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      dir_r     <= dir_nxt;
      elapsed_r <= elapsed_nxt;
      since_r   <= since_nxt;
    end
  end

endmodule

@@ src/ags_out_buf.sv @@
// Result register with a skid stage that can take one more result while the output is stalled.
module ags_out_buf
  import ags_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ags_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output ags_out_t out_data
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  ags_out_t out_data_r, out_data_nxt;
  ags_out_t skid_data_r, skid_data_nxt;
  logic     pop;

  always_comb begin
    pop            = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/access_gate_sequencer.sv @@
// Top level of the access gate sequencer: config registers, step logic, result buffer.
// Each accepted request's result is registered on out_data, or in the skid stage while an older result waits.
// Throughput: one request per cycle while in_stall is low; the phase logic and timer updates are combinational.
// in_stall rises only while the skid stage holds a second waiting result.
// Reset: synchronous active-low rst_n; phase waiting, timers zero, registers to defaults.
// cfg_ready is always high; a write lands at the edge where cfg_valid is high.
module access_gate_sequencer
  import ags_pkg::*;
#(
  parameter int TIMER_BITS    = AGS_TIMER_BITS,
  parameter int DISTANCE_BITS = AGS_DISTANCE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ags_in_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ags_out_t                out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  ags_idx_t                cfg_index,
  input  logic [AGS_CFG_BITS-1:0] cfg_data
);

  ags_cfg_t cfg;
  ags_out_t result;
  logic     full;
  logic     accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  ags_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ags_step #(
    .TIMER_BITS    (TIMER_BITS),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_data),
    .cfg    (cfg),
    .result (result)
  );

  ags_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ src/ags_checker.sv @@
// Port-level checks for the access gate sequencer, bound to the top level.
module ags_checker
  import ags_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ags_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_req_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  a_open_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.door_command == DOOR_ENTRY) |->
    (out_data.display_code == DISP_WELCOME && out_data.phase == PH_PASS_WAIT))
    else $error("entry open without welcome and passage wait");

  a_waiting_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.display_code == DISP_WAITING) |-> (out_data.phase == PH_WAIT))
    else $error("waiting display outside waiting phase");

  a_log_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.log_event == LOG_NONE) |-> !out_data.log_is_entry)
    else $error("direction flagged without log event");

endmodule

bind access_gate_sequencer ags_checker u_ags_checker (.*);
